// ===== design/msc_pkg.sv =====
// msc_pkg: shared types, constants and helper functions of the material sorter controller
// used by msc_ctrl, msc_datapath and material_sorter_controller_top
`default_nettype none

package msc_pkg;

    // class fifo geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int SAMPLE_W = 10;
    localparam int THR_W    = 10;
    localparam int MIN_W    = 11;
    localparam int CLASS_W  = 2;
    localparam int ROT_W    = 2;
    localparam int TALLY_W  = 8;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 2;

    // result word layout
    localparam int OUT_BITS    = CLASS_W + 1 + ROT_W + 1 + 4 * TALLY_W + QFILL_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;

    localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(1024);

    localparam logic [THR_W-1:0] BLACK_THR_RESET = THR_W'(930);
    localparam logic [THR_W-1:0] WHITE_THR_RESET = THR_W'(700);
    localparam logic [THR_W-1:0] STEEL_THR_RESET = THR_W'(300);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_THR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_THR = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_STEEL_THR = CFG_IDX_W'(2);

    // class codes
    localparam logic [CLASS_W-1:0] CLS_BLACK = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_STEEL = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_WHITE = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_ALUM  = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE  = 2'd0,
        OP_OBJ_END = 2'd1,
        OP_DROP    = 2'd2,
        OP_RAMP    = 2'd3
    } op_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // latch the incoming word and start the fifo head read
        logic commit;   // apply the latched word and load the result register
    } ctrl_cmd_t;

    function automatic logic [CLASS_W-1:0] classify(
        input logic [MIN_W-1:0] m,
        input logic [THR_W-1:0] black_thr,
        input logic [THR_W-1:0] white_thr,
        input logic [THR_W-1:0] steel_thr
    );
        logic [CLASS_W-1:0] c;
        if (m > MIN_W'(black_thr))
            c = CLS_BLACK;
        else if (m > MIN_W'(white_thr))
            c = CLS_WHITE;
        else if (m > MIN_W'(steel_thr))
            c = CLS_STEEL;
        else
            c = CLS_ALUM;
        return c;
    endfunction

    function automatic logic [QPTR_W-1:0] next_slot(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] n;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            n = '0;
        else
            n = p + 1'b1;
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== design/msc_ram.sv =====
// msc_ram: generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module msc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/msc_ctrl.sv =====
// msc_ctrl: sequencing state machine and result-valid flag of the sorter controller
// depends on msc_pkg
`default_nettype none

module msc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output msc_pkg::ctrl_cmd_t  cmd
);

    import msc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // result slot free or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("pending result dropped");
    a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_EXEC))
        else $error("load did not start execution");
    a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("commit did not present a result");
`endif

endmodule

`default_nettype wire

// ===== design/msc_datapath.sv =====
// msc_datapath: thresholds, running minimum, fifo pointers, tallies, tray and result register
// depends on msc_pkg; drives an external msc_ram holding the class fifo
`default_nettype none

module msc_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  msc_pkg::ctrl_cmd_t              cmd,
    input  logic [msc_pkg::OP_W-1:0]        in_op,
    input  logic [msc_pkg::SAMPLE_W-1:0]    in_sample,
    input  logic                            cfg_we,
    input  logic [msc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msc_pkg::THR_W-1:0]       cfg_data,
    output logic                            ram_we,
    output logic [msc_pkg::QPTR_W-1:0]      ram_waddr,
    output logic [msc_pkg::CLASS_W-1:0]     ram_wdata,
    output logic                            ram_re,
    output logic [msc_pkg::QPTR_W-1:0]      ram_raddr,
    input  logic [msc_pkg::CLASS_W-1:0]     ram_rdata,
    output logic [msc_pkg::CLASS_W-1:0]     item_class,
    output logic                            class_valid,
    output logic [msc_pkg::ROT_W-1:0]       rotate_command,
    output logic                            queue_error,
    output logic [msc_pkg::TALLY_W-1:0]     count_black,
    output logic [msc_pkg::TALLY_W-1:0]     count_steel,
    output logic [msc_pkg::TALLY_W-1:0]     count_white,
    output logic [msc_pkg::TALLY_W-1:0]     count_alum,
    output logic [msc_pkg::QFILL_W-1:0]     in_transit,
    output logic                            finished
);

    import msc_pkg::*;

    logic [THR_W-1:0]   black_thr_reg, white_thr_reg, steel_thr_reg;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic               seen_reg, seen_next;
    logic [QPTR_W-1:0]  head_reg, head_next, tail_reg, tail_next;
    logic [QFILL_W-1:0] fill_reg, fill_next;
    logic [TALLY_W-1:0] tally_reg [4];
    logic [TALLY_W-1:0] tally_next [4];
    logic [CLASS_W-1:0] tray_reg, tray_next;
    logic               armed_reg, armed_next;
    logic               done_reg, done_next;

    op_t                op_reg;
    logic [SAMPLE_W-1:0] smp_reg;

    logic [CLASS_W-1:0] cls_reg, cls_next;
    logic               valid_reg, valid_next;
    logic [ROT_W-1:0]   rot_reg, rot_next;
    logic               err_reg, err_next;

    logic               q_full, q_empty;
    logic [CLASS_W-1:0] min_cls;

    assign q_full  = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign q_empty = (fill_reg == '0);
    assign min_cls = classify(min_reg, black_thr_reg, white_thr_reg, steel_thr_reg);

    // head entry read is started with the word latch, data is ready at commit
    assign ram_re    = cmd.load;
    assign ram_raddr = head_reg;
    assign ram_waddr = tail_reg;
    assign ram_wdata = min_cls;
    assign ram_we    = cmd.commit && (op_reg == OP_OBJ_END) && seen_reg && !q_full;

    always_comb
    begin
        min_next   = min_reg;
        seen_next  = seen_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        tally_next = tally_reg;
        tray_next  = tray_reg;
        armed_next = armed_reg;
        done_next  = done_reg;
        cls_next   = cls_reg;
        valid_next = valid_reg;
        rot_next   = rot_reg;
        err_next   = err_reg;

        if (cmd.commit)
        begin
            cls_next   = CLS_BLACK;
            valid_next = 1'b0;
            rot_next   = '0;
            err_next   = 1'b0;
            unique case (op_reg)
                OP_SAMPLE:
                begin
                    if (MIN_W'(smp_reg) < min_reg)
                        min_next = MIN_W'(smp_reg);
                    seen_next = 1'b1;
                end
                OP_OBJ_END:
                begin
                    if (seen_reg)
                    begin
                        cls_next   = min_cls;
                        valid_next = 1'b1;
                        if (q_full)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            tail_next = next_slot(tail_reg);
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    min_next  = MIN_RESET;
                    seen_next = 1'b0;
                end
                OP_DROP:
                begin
                    if (q_empty)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        cls_next              = ram_rdata;
                        valid_next            = 1'b1;
                        head_next             = next_slot(head_reg);
                        fill_next             = fill_reg - 1'b1;
                        tally_next[ram_rdata] = tally_reg[ram_rdata] + 1'b1;
                        rot_next              = ram_rdata - tray_reg;
                        tray_next             = ram_rdata;
                        if (armed_reg && fill_reg == QFILL_W'(1))
                            done_next = 1'b1;
                    end
                end
                OP_RAMP:
                begin
                    armed_next = 1'b1;
                end
                default:
                begin
                    armed_next = armed_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_thr_reg <= BLACK_THR_RESET;
            white_thr_reg <= WHITE_THR_RESET;
            steel_thr_reg <= STEEL_THR_RESET;
            min_reg       <= MIN_RESET;
            seen_reg      <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            for (int i = 0; i < 4; i++)
            begin
                tally_reg[i] <= '0;
            end
            tray_reg      <= CLS_BLACK;
            armed_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BLACK_THR: black_thr_reg <= cfg_data;
                    REG_WHITE_THR: white_thr_reg <= cfg_data;
                    REG_STEEL_THR: steel_thr_reg <= cfg_data;
                    default:       black_thr_reg <= black_thr_reg;
                endcase
            end
            min_reg   <= min_next;
            seen_reg  <= seen_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            tally_reg <= tally_next;
            tray_reg  <= tray_next;
            armed_reg <= armed_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(in_op);
            smp_reg <= in_sample;
        end
        cls_reg   <= cls_next;
        valid_reg <= valid_next;
        rot_reg   <= rot_next;
        err_reg   <= err_next;
    end

    // state only moves at commit, so live tallies, fill and flag match the result
    assign item_class     = cls_reg;
    assign class_valid    = valid_reg;
    assign rotate_command = rot_reg;
    assign queue_error    = err_reg;
    assign count_black    = tally_reg[CLS_BLACK];
    assign count_steel    = tally_reg[CLS_STEEL];
    assign count_white    = tally_reg[CLS_WHITE];
    assign count_alum     = tally_reg[CLS_ALUM];
    assign in_transit     = fill_reg;
    assign finished       = done_reg;

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= QFILL_W'(QUEUE_DEPTH))
        else $error("fifo fill out of range");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (q_empty || q_full) |-> (head_reg == tail_reg))
        else $error("fifo pointers disagree with fill");
    a_done_armed: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> armed_reg)
        else $error("finish flag without ramp-down");
    a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && op_reg == OP_DROP && q_empty) |=>
        (err_reg && !valid_reg && fill_reg == '0))
        else $error("empty drop not flagged");
    a_min_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && op_reg == OP_OBJ_END) |=> (min_reg == MIN_RESET && !seen_reg))
        else $error("minimum not restarted at object end");
`endif

endmodule

`default_nettype wire

// ===== design/material_sorter_controller_top.sv =====
// material_sorter_controller_top: conveyor sorter controller, stream in and stream out
// depends on msc_pkg, msc_ram, msc_ctrl, msc_datapath
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | s_tuser operation, s_tdata sample
//  m_*     | out       | m_tvalid/m_tready  | m_tdata result word, one per input word
//  cfg_*   | in        | cfg_we             | cfg_index register, cfg_data threshold
//
// each word has an accept cycle that latches it and starts the
// registered read of the fifo head, then a commit cycle that updates all state
// reset restores the default thresholds and an empty fifo; the fifo ram is not
// cleared since only entries counted in the fill are ever read
// a result waits in the output register; the next word is still accepted, and
// its commit holds until the waiting result is taken
`default_nettype none

module material_sorter_controller_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [9:0] sample, upper bits zero
    input  logic [msc_pkg::IN_TDATA_W-1:0]       s_tdata,
    // [1:0] operation
    input  logic [msc_pkg::OP_W-1:0]             s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [1:0] item_class, [2] class_valid, [4:3] rotate_command, [5] queue_error,
    // [13:6] count_black, [21:14] count_steel, [29:22] count_white,
    // [37:30] count_alum, [42:38] in_transit, [43] finished, rest zero
    output logic [msc_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                 cfg_we,
    input  logic [msc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [msc_pkg::THR_W-1:0]            cfg_data
);

    import msc_pkg::*;

    ctrl_cmd_t          cmd;

    // class fifo storage
    logic               ram_we;
    logic [QPTR_W-1:0]  ram_waddr;
    logic [CLASS_W-1:0] ram_wdata;
    logic               ram_re;
    logic [QPTR_W-1:0]  ram_raddr;
    logic [CLASS_W-1:0] ram_rdata;

    // result fields
    logic [CLASS_W-1:0] item_class;
    logic               class_valid;
    logic [ROT_W-1:0]   rotate_command;
    logic               queue_error;
    logic [TALLY_W-1:0] count_black;
    logic [TALLY_W-1:0] count_steel;
    logic [TALLY_W-1:0] count_white;
    logic [TALLY_W-1:0] count_alum;
    logic [QFILL_W-1:0] in_transit;
    logic               finished;

    msc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    msc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .in_op          (s_tuser),
        .in_sample      (s_tdata[SAMPLE_W-1:0]),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .item_class     (item_class),
        .class_valid    (class_valid),
        .rotate_command (rotate_command),
        .queue_error    (queue_error),
        .count_black    (count_black),
        .count_steel    (count_steel),
        .count_white    (count_white),
        .count_alum     (count_alum),
        .in_transit     (in_transit),
        .finished       (finished)
    );

    msc_ram #(
        .WIDTH (CLASS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_class_fifo (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // pack the result word, first field lowest
    assign m_tdata = OUT_TDATA_W'({finished, in_transit, count_alum, count_white,
                                   count_steel, count_black, queue_error,
                                   rotate_command, class_valid, item_class});

endmodule

`default_nettype wire
